// ===== hdl/dxs_pkg.sv =====
// ----------------------------------------------------------------------------
// dxs_pkg: shared definitions for the double exponential smoother
// Default sizes, register map codes and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package dxs_pkg;

    // Default sizes
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int GAIN_BITS_DEF   = 16;

    // Bits of a gain register taken from a write word
    localparam int CFG_GAIN_BITS = 17;

    // Register map: word index taken from paddr[2]
    localparam int APB_ADDR_BITS = 3;
    localparam logic REG_LEVEL_GAIN = 1'b0;
    localparam logic REG_TREND_GAIN = 1'b1;

    // Operand width of the shared multiplier (level + trend or a level step)
    localparam int OPND_BITS = 34;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            return 32'sh7fffffff;
        end
        if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== hdl/dxs_mult.sv =====
// ----------------------------------------------------------------------------
// dxs_mult: shared gain multiplier
// Registers gain * operand each cycle and presents the product rounded to
// nearest (halves toward plus infinity) and scaled back by 2^GAIN_BITS.
// ----------------------------------------------------------------------------
module dxs_mult
    import dxs_pkg::*;
#(
    parameter int GAIN_BITS = GAIN_BITS_DEF,
    parameter int OPW       = OPND_BITS
)
(
    input  logic                          clk,
    input  logic [GAIN_BITS:0]            gain,
    input  logic signed [OPW-1:0]         operand,
    output logic signed [OPW+1:0]         rounded
);

    localparam int PW = OPW + GAIN_BITS + 2;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (GAIN_BITS - 1);

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_rnd;

    // Multiply, gain taken as non-negative
    always_ff @(posedge clk)
    begin
        prod_reg <= $signed({1'b0, gain}) * operand;
    end

    // Round and drop the gain fraction
    assign prod_rnd = prod_reg + HALF;
    assign rounded  = prod_rnd[PW-1:GAIN_BITS];

endmodule

// ===== hdl/double_exponential_smoother.sv =====
// ----------------------------------------------------------------------------
// double_exponential_smoother: Holt linear-trend smoother
// Keeps a level and a trend (signed 32-bit, FRAC_BITS fraction bits) and
// emits level + trend for every sample, with gains set over an APB port.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  sample    in         sample_valid / sample_ready   sample [SAMPLE_BITS]
//  smoothed  out        smoothed_valid/smoothed_ready smoothed [32]
//  config    in         psel/penable/pwrite/pready    paddr [3], pwdata/prdata [32]
//
// After a sample is taken, the sequencer runs from S_MUL_LX to S_EMIT before
// sample_ready rises again: four products pass one after another through the
// single shared multiplier, with a saturating add after each pair. The result
// word enters an output register, so a new sample is taken while it waits. If
// the previous word is still not taken when the next one is done, the
// sequencer holds. Reset clears level and trend and sets both gains to one.
// ----------------------------------------------------------------------------
module double_exponential_smoother
    import dxs_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int GAIN_BITS   = GAIN_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          smoothed_valid,
    input  logic                          smoothed_ready,
    output logic signed [31:0]            smoothed,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_BITS-1:0]      paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int GL   = GAIN_BITS + 1;
    localparam int OPW  = OPND_BITS;
    localparam int ACCW = OPW + 2;
    localparam int CW   = (GL > CFG_GAIN_BITS) ? GL : CFG_GAIN_BITS;
    localparam logic [GL-1:0] GAIN_ONE = {1'b1, {GAIN_BITS{1'b0}}};

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MUL_LX = 8'b0000_0010,
        S_MUL_LT = 8'b0000_0100,
        S_LEVEL  = 8'b0000_1000,
        S_MUL_TD = 8'b0001_0000,
        S_MUL_TT = 8'b0010_0000,
        S_TREND  = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [GL-1:0]            level_gain_reg;
    logic [GL-1:0]            trend_gain_reg;
    logic signed [31:0]       level_reg;
    logic signed [31:0]       trend_reg;
    logic signed [31:0]       x_reg;
    logic signed [ACCW-1:0]   acc_reg;
    logic signed [31:0]       lnew_reg;
    logic signed [31:0]       smoothed_reg;
    logic                     smoothed_valid_reg;

    logic [GL-1:0]            mul_gain;
    logic signed [OPW-1:0]    mul_opnd;
    logic signed [ACCW-1:0]   mul_rnd;
    logic signed [ACCW-1:0]   pair_sum;
    logic signed [63:0]       x_wide;
    logic                     cfg_write;
    logic [CW-1:0]            wr_gain;
    logic [CW-1:0]            wr_gain_clamped;
    logic                     emit_load;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign wr_gain   = CW'(pwdata[CFG_GAIN_BITS-1:0]);
    assign wr_gain_clamped = (wr_gain > CW'(GAIN_ONE)) ? CW'(GAIN_ONE) : wr_gain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_gain_reg <= GAIN_ONE;
            trend_gain_reg <= GAIN_ONE;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_LEVEL_GAIN: level_gain_reg <= GL'(wr_gain_clamped);
                REG_TREND_GAIN: trend_gain_reg <= GL'(wr_gain_clamped);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_LEVEL_GAIN: prdata = 32'(level_gain_reg);
            REG_TREND_GAIN: prdata = 32'(trend_gain_reg);
            default:        prdata = '0;
        endcase
    end

    // Sequencer
    assign sample_ready = (state_reg == S_IDLE);
    assign emit_load    = !smoothed_valid_reg || smoothed_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (sample_valid) state_next = S_MUL_LX;
            S_MUL_LX: state_next = S_MUL_LT;
            S_MUL_LT: state_next = S_LEVEL;
            S_LEVEL:  state_next = S_MUL_TD;
            S_MUL_TD: state_next = S_MUL_TT;
            S_MUL_TT: state_next = S_TREND;
            S_TREND:  state_next = S_EMIT;
            S_EMIT:   if (emit_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Select the multiplier operands for each product
    always_comb
    begin
        mul_gain = '0;
        mul_opnd = '0;
        unique case (state_reg)
            S_MUL_LX:
            begin
                mul_gain = level_gain_reg;
                mul_opnd = OPW'(x_reg);
            end
            S_MUL_LT:
            begin
                mul_gain = GAIN_ONE - level_gain_reg;
                mul_opnd = OPW'(level_reg) + OPW'(trend_reg);
            end
            S_MUL_TD:
            begin
                mul_gain = trend_gain_reg;
                mul_opnd = OPW'(lnew_reg) - OPW'(level_reg);
            end
            S_MUL_TT:
            begin
                mul_gain = GAIN_ONE - trend_gain_reg;
                mul_opnd = OPW'(trend_reg);
            end
            default: ;
        endcase
    end

    dxs_mult #(
        .GAIN_BITS (GAIN_BITS),
        .OPW       (OPW)
    ) u_mult (
        .clk     (clk),
        .gain    (mul_gain),
        .operand (mul_opnd),
        .rounded (mul_rnd)
    );

    // Scale the sample into the fixed-point format
    assign x_wide   = 64'(sample) <<< FRAC_BITS;
    assign pair_sum = acc_reg + mul_rnd;

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            x_reg <= sat32(x_wide);
        end
        if (state_reg == S_MUL_LT || state_reg == S_MUL_TT)
        begin
            acc_reg <= mul_rnd;
        end
        if (state_reg == S_LEVEL)
        begin
            lnew_reg <= sat32(64'(pair_sum));
        end
        if (state_reg == S_EMIT && emit_load)
        begin
            smoothed_reg <= sat32(64'(level_reg) + 64'(trend_reg));
        end
    end

    // Commit the new level and trend
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            trend_reg <= '0;
        end
        else if (state_reg == S_TREND)
        begin
            level_reg <= lnew_reg;
            trend_reg <= sat32(64'(pair_sum));
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_valid_reg <= 1'b0;
        end
        else if (state_reg == S_EMIT && emit_load)
        begin
            smoothed_valid_reg <= 1'b1;
        end
        else if (smoothed_ready)
        begin
            smoothed_valid_reg <= 1'b0;
        end
    end

    assign smoothed_valid = smoothed_valid_reg;
    assign smoothed       = smoothed_reg;

endmodule

// ===== hdl/dxs_checker.sv =====
// ----------------------------------------------------------------------------
// dxs_checker: port-level checks for the double exponential smoother
// Watches the handshakes and the configuration port over time.
// ----------------------------------------------------------------------------
module dxs_checker
    import dxs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        sample_valid,
    input logic        sample_ready,
    input logic        smoothed_valid,
    input logic        smoothed_ready,
    input logic [31:0] smoothed,
    input logic        pready
);

    // The configuration port never inserts wait cycles
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // Block is busy right after taking a word
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
        else $error("sample taken back to back");

    // A new result only appears after a word was being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(smoothed_valid) |-> !$past(sample_ready))
        else $error("result without work in flight");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (smoothed_valid && !smoothed_ready) |=> (smoothed_valid && $stable(smoothed)))
        else $error("stalled result changed");

endmodule

bind double_exponential_smoother dxs_checker u_dxs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .smoothed_valid (smoothed_valid),
    .smoothed_ready (smoothed_ready),
    .smoothed       (smoothed),
    .pready         (pready)
);
